// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers. Each one samples on clk and is disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge.
`define ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fcse_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcse_pkg
// Shared types, constants and arithmetic helpers of the symbol encoder.
// ---------------------------------------------------------------------------
package fcse_pkg;

  // Field widths
  localparam int IDX_W      = 12;
  localparam int CFG_W      = 12;
  localparam int LT_DEG_W   = 5;
  localparam int PI_DEG_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int RED_BIT_W  = 4;
  localparam int SKIP_W     = 13;

  // Parameter defaults
  localparam int DEF_MAX_SYMBOLS = 4096;
  localparam int DEF_SLICE_BITS  = 64;

  // Skip search gives up after this many steps
  localparam logic [SKIP_W-1:0] SKIP_LIMIT = 13'd4096;

  // Top bit of a reduced operand, first bit fed into the remainder lanes
  localparam logic [RED_BIT_W-1:0] RED_TOP = RED_BIT_W'(CFG_W - 1);

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PI_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PI_PRIME = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic                 load_tuple;
    logic                 mem_write;
    logic                 red_step;
    logic [RED_BIT_W-1:0] red_bit;
    logic                 lt_issue;
    logic                 pi_skip;
    logic                 pi_issue;
    logic                 pi_advance;
    logic                 out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_needed;
  } sts_t;

  // One restoring-remainder step: shift in a bit, subtract the modulus if it fits
  function automatic logic [CFG_W-1:0] rem_step(input logic [CFG_W-1:0] r,
                                                input logic             b,
                                                input logic [CFG_W-1:0] m);
    logic [CFG_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[CFG_W-1:0];
  endfunction

  // Modular add of two operands already below the modulus
  function automatic logic [CFG_W-1:0] mod_add(input logic [CFG_W-1:0] x,
                                               input logic [CFG_W-1:0] y,
                                               input logic [CFG_W-1:0] m);
    logic [CFG_W:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[CFG_W-1:0];
  endfunction

endpackage

// ===== rtl/fountain_code_symbol_encoder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fountain_code_symbol_encoder_top
// Encoded symbol slice generator: XORs stored intermediate symbol slices
// chosen by a precomputed (d, a, b, d1, a1, b1) tuple.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | op, entry_index, entry_data, tuple fields
//  out     | out_valid / out_stall| encoded_slice
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A write transaction is written to the store as it is taken. An encode
//  transaction makes max(d,1) LT reads and d1' PI reads, with d1' = max(d1,1):
//  operand reduction first (one remainder bit per cycle), then one store read
//  per cycle through the single store port, paused during PI skip steps.
//  Reset is synchronous, clears control and sets the three registers to one;
//  the store is undefined.
//  A result stalled on the output holds there while the next transaction
//  is taken; a finishing encode waits until the output register is free.
// ---------------------------------------------------------------------------
module fountain_code_symbol_encoder_top
  import fcse_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int SLICE_BITS  = DEF_SLICE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [SLICE_BITS-1:0] entry_data,
  input  logic [LT_DEG_W-1:0]   lt_degree,
  input  logic [CFG_W-1:0]      lt_step,
  input  logic [CFG_W-1:0]      lt_start,
  input  logic [PI_DEG_W-1:0]   pi_degree,
  input  logic [CFG_W-1:0]      pi_step,
  input  logic [CFG_W-1:0]      pi_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLICE_BITS-1:0] encoded_slice,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  fcse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .lt_degree (lt_degree),
    .pi_degree (pi_degree),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcse_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .SLICE_BITS  (SLICE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry_index   (entry_index),
    .entry_data    (entry_data),
    .lt_step       (lt_step),
    .lt_start      (lt_start),
    .pi_step       (pi_step),
    .pi_start      (pi_start),
    .encoded_slice (encoded_slice)
  );

endmodule

// ===== rtl/fcse_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcse_ctrl
// Controller: sequences operand reduction, LT reads, PI skip search and reads,
// and owns the output valid flag.
// ---------------------------------------------------------------------------
module fcse_ctrl
  import fcse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                op,
  input  logic [LT_DEG_W-1:0] lt_degree,
  input  logic [PI_DEG_W-1:0] pi_degree,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  input  sts_t                sts,
  output cmd_t                cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_LT     = 3'd2;
  localparam logic [2:0] S_PI     = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0]           state, state_next;
  logic [RED_BIT_W-1:0] bit_cnt, bit_cnt_next;
  logic [LT_DEG_W-1:0]  lt_left, lt_left_next;
  logic [PI_DEG_W-1:0]  pi_left, pi_left_next;
  logic                 out_valid_next;

  // Take a transaction only while idle
  assign in_stall = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    cmd            = '0;
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    lt_left_next   = lt_left;
    pi_left_next   = pi_left;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_WRITE) begin
            cmd.mem_write = 1'b1;
          end else begin
            cmd.load_tuple = 1'b1;
            lt_left_next   = (lt_degree == '0) ? LT_DEG_W'(1) : lt_degree;
            pi_left_next   = (pi_degree < 2'd2) ? PI_DEG_W'(1) : pi_degree;
            bit_cnt_next   = RED_TOP;
            state_next     = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        cmd.red_bit  = bit_cnt;
        if (bit_cnt == '0) begin
          state_next = S_LT;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      S_LT: begin
        cmd.lt_issue = 1'b1;
        if (lt_left == LT_DEG_W'(1)) begin
          state_next = S_PI;
        end else begin
          lt_left_next = lt_left - 1'b1;
        end
      end
      S_PI: begin
        if (sts.skip_needed) begin
          cmd.pi_skip = 1'b1;
        end else begin
          cmd.pi_issue = 1'b1;
          if (pi_left == PI_DEG_W'(1)) begin
            state_next = S_FLUSH;
          end else begin
            cmd.pi_advance = 1'b1;
            pi_left_next   = pi_left - 1'b1;
          end
        end
      end
      S_FLUSH: begin
        // Hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      lt_left   <= '0;
      pi_left   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      lt_left   <= lt_left_next;
      pi_left   <= pi_left_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/fcse_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcse_dp
// Datapath: configuration registers, remainder lanes, index stepping, the
// single-port symbol store, the XOR accumulator and the output register.
// ---------------------------------------------------------------------------
module fcse_dp
  import fcse_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int SLICE_BITS  = DEF_SLICE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [SLICE_BITS-1:0] entry_data,
  input  logic [CFG_W-1:0]      lt_step,
  input  logic [CFG_W-1:0]      lt_start,
  input  logic [CFG_W-1:0]      pi_step,
  input  logic [CFG_W-1:0]      pi_start,
  output logic [SLICE_BITS-1:0] encoded_slice
);

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int CW = (AW + 1 > IDX_W + 1) ? AW + 1 : IDX_W + 1;

  // Configuration
  logic [CFG_W-1:0] lt_count, pi_count, pi_prime;
  logic [CFG_W-1:0] lt_mod, pi_mod;

  // Tuple state: raw index, its reduced form, raw and reduced increments
  logic [CFG_W-1:0]  lt_idx, lt_red, lt_inc, lt_inc_red;
  logic [CFG_W-1:0]  pi_cand, pi_red, pi_inc, pi_inc_red;
  logic [SKIP_W-1:0] skip_n;
  logic [CFG_W-1:0]  lt_next, pi_next;

  // Store and accumulator
  logic [SLICE_BITS-1:0] mem [MAX_SYMBOLS];
  logic [SLICE_BITS-1:0] rd_data;
  logic                  rd_pend, rd_ok;
  logic [SLICE_BITS-1:0] acc, acc_next;
  logic [CFG_W:0]        pi_addr;
  logic [CW-1:0]         rd_ext, wr_ext;
  logic                  rd_en, rd_in, wr_in;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      lt_count <= CFG_W'(1);
      pi_count <= CFG_W'(1);
      pi_prime <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LT_COUNT: lt_count <= cfg_data;
        REG_PI_COUNT: pi_count <= cfg_data;
        REG_PI_PRIME: pi_prime <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero modulus acts as one
  assign lt_mod = (lt_count == '0) ? CFG_W'(1) : lt_count;
  assign pi_mod = (pi_prime == '0) ? CFG_W'(1) : pi_prime;

  assign lt_next = mod_add(lt_red, lt_inc_red, lt_mod);
  assign pi_next = mod_add(pi_red, pi_inc_red, pi_mod);

  assign sts.skip_needed = (pi_cand >= pi_count) && (skip_n != SKIP_LIMIT);

  // Load, reduce and advance the tuple
  always_ff @(posedge clk) begin
    if (cmd.load_tuple) begin
      lt_idx     <= lt_start;
      lt_inc     <= lt_step;
      pi_cand    <= pi_start;
      pi_inc     <= pi_step;
      lt_red     <= '0;
      lt_inc_red <= '0;
      pi_red     <= '0;
      pi_inc_red <= '0;
      skip_n     <= '0;
    end else begin
      if (cmd.red_step) begin
        lt_red     <= rem_step(lt_red, lt_idx[cmd.red_bit], lt_mod);
        lt_inc_red <= rem_step(lt_inc_red, lt_inc[cmd.red_bit], lt_mod);
        pi_red     <= rem_step(pi_red, pi_cand[cmd.red_bit], pi_mod);
        pi_inc_red <= rem_step(pi_inc_red, pi_inc[cmd.red_bit], pi_mod);
      end
      if (cmd.lt_issue) begin
        lt_idx <= lt_next;
        lt_red <= lt_next;
      end
      if (cmd.pi_skip) begin
        pi_cand <= pi_next;
        pi_red  <= pi_next;
        skip_n  <= skip_n + 1'b1;
      end
      if (cmd.pi_advance) begin
        pi_cand <= pi_next;
        pi_red  <= pi_next;
        skip_n  <= '0;
      end
    end
  end

  // Store addressing; anything at or beyond the depth is out of range
  assign pi_addr = {1'b0, lt_count} + {1'b0, pi_cand};
  assign rd_en   = cmd.lt_issue || cmd.pi_issue;
  assign rd_ext  = cmd.lt_issue ? CW'(lt_idx) : CW'(pi_addr);
  assign rd_in   = (rd_ext < CW'(MAX_SYMBOLS));
  assign wr_ext  = CW'(entry_index);
  assign wr_in   = (wr_ext < CW'(MAX_SYMBOLS));

  // Single-port store with registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_in) begin
      mem[wr_ext[AW-1:0]] <= entry_data;
    end else if (rd_en && rd_in) begin
      rd_data <= mem[rd_ext[AW-1:0]];
    end
  end

  // Track reads in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      rd_ok   <= rd_in;
    end
  end

  // Accumulate returned slices; out-of-range reads add zero
  assign acc_next = (rd_pend && rd_ok) ? (acc ^ rd_data) : acc;

  always_ff @(posedge clk) begin
    if (cmd.load_tuple) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
    if (cmd.out_load) begin
      encoded_slice <= acc_next;
    end
  end

endmodule

// ===== rtl/fcse_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcse_checker
// Port-level checks of the symbol encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcse_checker
  import fcse_pkg::*;
#(
  parameter int SLICE_BITS = DEF_SLICE_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  op,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [SLICE_BITS-1:0] encoded_slice
);

  // A stalled result stays put
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(encoded_slice), "stalled result changed")

  // An accepted encode transaction keeps the input busy
  `ASSERT_NEXT(a_enc_busy, in_valid && !in_stall && op == OP_ENCODE, in_stall, "input free after encode accept")

  // A write transaction never produces a result
  `ASSERT_NEXT(a_wr_quiet, in_valid && !in_stall && op == OP_WRITE && !out_valid, !out_valid, "result after write")

  // A fresh result comes with the input free again
  `ASSERT_IMP(a_done_idle, $rose(out_valid), !in_stall, "input busy when result appears")

endmodule

bind fountain_code_symbol_encoder_top fcse_checker #(
  .SLICE_BITS (SLICE_BITS)
) u_checker (.*);

// ===== verif/fcse_slice_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcse_slice_checker
// Watches the input, output and register channels of the symbol encoder.
// Keeps its own copy of the symbol store and the three registers. Predicts
// each encoded slice when its transaction is taken, and compares every slice
// that leaves the block against the oldest prediction.
// ---------------------------------------------------------------------------
module fcse_slice_checker
  import fcse_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int SLICE_BITS  = DEF_SLICE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  op,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [SLICE_BITS-1:0] entry_data,
  input  logic [LT_DEG_W-1:0]   lt_degree,
  input  logic [CFG_W-1:0]      lt_step,
  input  logic [CFG_W-1:0]      lt_start,
  input  logic [PI_DEG_W-1:0]   pi_degree,
  input  logic [CFG_W-1:0]      pi_step,
  input  logic [CFG_W-1:0]      pi_start,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SLICE_BITS-1:0] encoded_slice,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    err_count,
  output int                    pending
);

  localparam int unsigned SKIP_STEPS = 4096;

  logic [SLICE_BITS-1:0] slice_mem [MAX_SYMBOLS];
  logic [CFG_W-1:0]      lt_cnt;
  logic [CFG_W-1:0]      pi_cnt;
  logic [CFG_W-1:0]      pi_mod;
  logic [SLICE_BITS-1:0] due_slices [$];

  // Reads past the end of the store give zero
  function automatic logic [SLICE_BITS-1:0] mem_rd(input int unsigned idx);
    return (idx >= MAX_SYMBOLS) ? '0 : slice_mem[idx];
  endfunction

  // Step a PI candidate until it lands below pi_count, giving up after a bound
  function automatic int unsigned pi_next_live(input int unsigned cand,
                                               input int unsigned step,
                                               input int unsigned modulus);
    int unsigned n;
    n = 0;
    while (cand >= pi_cnt && n < SKIP_STEPS) begin
      cand = (cand + step) % modulus;
      n++;
    end
    return cand;
  endfunction

  // XOR of the LT run and the PI run that the tuple selects
  function automatic logic [SLICE_BITS-1:0] xor_selected_slices(
    input int unsigned d, input int unsigned a, input int unsigned b,
    input int unsigned d1, input int unsigned a1, input int unsigned b1);
    int unsigned           w;
    int unsigned           p1;
    int unsigned           lt_idx;
    int unsigned           pi_idx;
    int unsigned           n_lt;
    int unsigned           n_pi;
    logic [SLICE_BITS-1:0] acc;
    w      = (lt_cnt == 0) ? 1 : lt_cnt;
    p1     = (pi_mod == 0) ? 1 : pi_mod;
    n_lt   = (d == 0) ? 1 : d;
    n_pi   = (d1 < 2) ? 1 : d1;
    // first LT index is taken as given, reduced only once stepping starts
    lt_idx = b;
    acc    = mem_rd(lt_idx);
    for (int j = 1; j < n_lt; j++) begin
      lt_idx = (lt_idx + a) % w;
      acc ^= mem_rd(lt_idx);
    end
    pi_idx = pi_next_live(b1, a1, p1);
    acc ^= mem_rd(lt_cnt + pi_idx);
    for (int j = 1; j < n_pi; j++) begin
      pi_idx = pi_next_live((pi_idx + a1) % p1, a1, p1);
      acc ^= mem_rd(lt_cnt + pi_idx);
    end
    return acc;
  endfunction

  initial begin
    err_count = 0;
    pending   = 0;
    foreach (slice_mem[i]) slice_mem[i] = '0;
  end

  // Track every transaction on the three channels
  always @(posedge clk) begin
    logic [SLICE_BITS-1:0] want;
    if (rst) begin
      lt_cnt = 1;
      pi_cnt = 1;
      pi_mod = 1;
      due_slices.delete();
    end else begin
      // compare a leaving slice with the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_slices.size() == 0) begin
          $display("%0t: encoded_slice %h arrived, expected none", $time, encoded_slice);
          err_count++;
        end else begin
          want = due_slices.pop_front();
          if (encoded_slice !== want) begin
            $display("%0t: encoded_slice expected %h, got %h", $time, want, encoded_slice);
            err_count++;
          end
        end
      end
      // update the store or predict the slice
      if (in_valid && !in_stall) begin
        if (op == OP_WRITE) begin
          if (entry_index < MAX_SYMBOLS) slice_mem[entry_index] = entry_data;
        end else begin
          due_slices.push_back(xor_selected_slices(lt_degree, lt_step, lt_start,
                                                   pi_degree, pi_step, pi_start));
        end
      end
      // follow register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LT_COUNT: lt_cnt = cfg_data;
          REG_PI_COUNT: pi_cnt = cfg_data;
          REG_PI_PRIME: pi_mod = cfg_data;
          default: ;
        endcase
      end
    end
    pending = due_slices.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the symbol encoder. Fills the low and high ends of the store,
// runs short directed encodes on corner settings (degree zero, zero moduli,
// endless skip search, reads past the store), then random phases with
// changing registers and changing idle rates on both sides, including one
// long receiver hold-off. Every encode reads filled entries or past the end.
// Checking lives in fcse_slice_checker.
// ---------------------------------------------------------------------------
module tb;
  import fcse_pkg::*;

  localparam int SLICE_W     = DEF_SLICE_BITS;
  localparam int MAX_ENTRIES = DEF_MAX_SYMBOLS;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int SETTLE_CYC  = 60;
  localparam int HOLD_CYC    = 400;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int FILL_LOW    = 256;
  localparam int FILL_HIGH   = 32;

  typedef struct {
    logic                op;
    logic [IDX_W-1:0]    entry_index;
    logic [SLICE_W-1:0]  entry_data;
    logic [LT_DEG_W-1:0] lt_degree;
    logic [CFG_W-1:0]    lt_step;
    logic [CFG_W-1:0]    lt_start;
    logic [PI_DEG_W-1:0] pi_degree;
    logic [CFG_W-1:0]    pi_step;
    logic [CFG_W-1:0]    pi_start;
  } sym_req_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [IDX_W-1:0]     entry_index;
  logic [SLICE_W-1:0]   entry_data;
  logic [LT_DEG_W-1:0]  lt_degree;
  logic [CFG_W-1:0]     lt_step;
  logic [CFG_W-1:0]     lt_start;
  logic [PI_DEG_W-1:0]  pi_degree;
  logic [CFG_W-1:0]     pi_step;
  logic [CFG_W-1:0]     pi_start;
  logic                 out_valid;
  logic                 out_stall;
  logic [SLICE_W-1:0]   encoded_slice;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int err_count;
  int pending;
  int cycle_cnt = 0;
  int send_pct  = 25;
  int recv_pct  = 64;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  fountain_code_symbol_encoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .entry_index   (entry_index),
    .entry_data    (entry_data),
    .lt_degree     (lt_degree),
    .lt_step       (lt_step),
    .lt_start      (lt_start),
    .pi_degree     (pi_degree),
    .pi_step       (pi_step),
    .pi_start      (pi_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .encoded_slice (encoded_slice),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  fcse_slice_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .entry_index   (entry_index),
    .entry_data    (entry_data),
    .lt_degree     (lt_degree),
    .lt_step       (lt_step),
    .lt_start      (lt_start),
    .pi_degree     (pi_degree),
    .pi_step       (pi_step),
    .pi_start      (pi_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .encoded_slice (encoded_slice),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .err_count     (err_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = ($urandom_range(99) < recv_pct);
    end
  end

  // Store write; the tuple fields carry junk
  function automatic sym_req_t mk_write(input int unsigned idx,
                                        input logic [SLICE_W-1:0] data);
    sym_req_t r;
    r.op          = OP_WRITE;
    r.entry_index = IDX_W'(idx);
    r.entry_data  = data;
    r.lt_degree   = LT_DEG_W'($urandom);
    r.lt_step     = CFG_W'($urandom);
    r.lt_start    = CFG_W'($urandom);
    r.pi_degree   = PI_DEG_W'($urandom);
    r.pi_step     = CFG_W'($urandom);
    r.pi_start    = CFG_W'($urandom);
    return r;
  endfunction

  // Encode request; the entry fields carry junk
  function automatic sym_req_t mk_encode(input int unsigned d, input int unsigned a,
                                         input int unsigned b, input int unsigned d1,
                                         input int unsigned a1, input int unsigned b1);
    sym_req_t r;
    r.op          = OP_ENCODE;
    r.entry_index = IDX_W'($urandom);
    r.entry_data  = {$urandom, $urandom};
    r.lt_degree   = LT_DEG_W'(d);
    r.lt_step     = CFG_W'(a);
    r.lt_start    = CFG_W'(b);
    r.pi_degree   = PI_DEG_W'(d1);
    r.pi_step     = CFG_W'(a1);
    r.pi_start    = CFG_W'(b1);
    return r;
  endfunction

  // Offer one transaction, idling first at random, and hold until taken
  task automatic push_req(input sym_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op          = r.op;
    entry_index = r.entry_index;
    entry_data  = r.entry_data;
    lt_degree   = r.lt_degree;
    lt_step     = r.lt_step;
    lt_start    = r.lt_start;
    pi_degree   = r.pi_degree;
    pi_step     = r.pi_step;
    pi_start    = r.pi_start;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = CFG_W'(val);
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, wait for every slice, then let a trailing write settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned p,
                            input int unsigned p1);
    wait_idle();
    cfg_write(REG_LT_COUNT, w);
    cfg_write(REG_PI_COUNT, p);
    cfg_write(REG_PI_PRIME, p1);
  endtask

  initial begin
    int unsigned w;
    int unsigned p;
    int unsigned p1;
    int unsigned roll;
    int unsigned d;
    bit          is_prime;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_WRITE;
    entry_index = '0;
    entry_data  = '0;
    lt_degree   = '0;
    lt_step     = '0;
    lt_start    = '0;
    pi_degree   = '0;
    pi_step     = '0;
    pi_start    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_LT_COUNT;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill both ends of the store; every encode below stays inside them
    // or reads past the end
    for (int i = 0; i < FILL_LOW; i++) begin
      push_req(mk_write(i, (i == 0) ? '1 : (i == 1) ? '0 : {$urandom, $urandom}));
    end
    for (int i = MAX_ENTRIES - FILL_HIGH; i < MAX_ENTRIES; i++) begin
      push_req(mk_write(i, {$urandom, $urandom}));
    end

    // Registers at reset: degree zero, widest tuple, unreduced first indices
    push_req(mk_encode(0, 1, 0, 0, 1, 0));
    push_req(mk_encode(30, 4094, 4094, 1, 4094, 4094));
    push_req(mk_encode(1, 1, 0, 3, 1, 0));

    // Zero moduli and zero pi_count: every skip search runs out
    set_config(0, 0, 0);
    push_req(mk_encode(3, 5, 100, 3, 7, 200));
    push_req(mk_encode(1, 4094, 4094, 2, 1, 0));

    // Non-prime PI modulus: endless searches, step equal to the modulus
    set_config(40, 3, 12);
    push_req(mk_encode(5, 7, 39, 3, 6, 9));
    push_req(mk_encode(2, 39, 0, 2, 12, 4));
    push_req(mk_encode(30, 1, 0, 3, 5, 11));
    push_req(mk_write(41, '1));
    push_req(mk_write(0, '0));
    push_req(mk_encode(2, 1, 0, 2, 1, 1));

    // Largest registers: PI reads land on the last entry and past the end of the store
    set_config(4095, 4095, 4095);
    push_req(mk_encode(30, 4094, 4094, 3, 4094, 4094));
    push_req(mk_encode(1, 1, 0, 2, 1, 0));

    // Random phases
    for (int k = 0; k < RAND_PHASES; k++) begin
      if (k == 2) begin
        send_pct = 64;
        recv_pct = 25;
      end else if (k == 4) begin
        send_pct = 0;
        recv_pct = 0;
      end
      if (k == 0) begin
        w = 1;
        p = 1;
      end else if (k == 3) begin
        // wider registers, still inside the low filled entries
        w = $urandom_range(100, 200);
        p = $urandom_range(21, 50);
      end else begin
        w = $urandom_range(2, 64);
        p = $urandom_range(1, 20);
      end
      // smallest prime not below pi_count
      p1 = p;
      do begin
        is_prime = (p1 >= 2);
        for (int f = 2; f * f <= p1; f++) begin
          if (p1 % f == 0) is_prime = 1'b0;
        end
        if (!is_prime) p1++;
      end while (!is_prime);
      if (k == 0) p1 = 1;
      set_config(w, p, p1);
      if (k == 0) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 25) begin
          push_req(mk_write($urandom_range(MAX_ENTRIES - 1),
                            ($urandom_range(15) == 0) ? '1 : {$urandom, $urandom}));
        end else if (roll < 88) begin
          // well-formed tuple for the current registers
          d = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 30);
          push_req(mk_encode(d,
                             (w > 1) ? $urandom_range(1, w - 1) : $urandom_range(1, 4094),
                             $urandom_range(0, w - 1),
                             $urandom_range(2, 3),
                             (p1 > 1) ? $urandom_range(1, p1 - 1) : $urandom_range(1, 4094),
                             $urandom_range(0, p1 - 1)));
        end else begin
          // anything the fields allow; the first LT index lands on a filled entry
          push_req(mk_encode($urandom_range(0, 30), $urandom_range(1, 4094),
                             $urandom_range(1) ? $urandom_range(0, FILL_LOW - 1)
                                               : $urandom_range(MAX_ENTRIES - FILL_HIGH,
                                                                4094),
                             $urandom_range(0, 3),
                             $urandom_range(1, 4094), $urandom_range(0, 4094)));
        end
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
